@@ hdl/ceq_pkg.sv @@
`default_nettype none
package ceq_pkg;
    localparam int QueueDepth = 16;
    localparam int IdxW = $clog2(QueueDepth);
    localparam int LvlW = $clog2(QueueDepth + 1);

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DRAIN = 2'd1;
    localparam logic [1:0] CMD_SNAP = 2'd2;

    localparam logic [1:0] RES_RECEIPT = 2'd0;
    localparam logic [1:0] RES_EVENT = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;
    localparam logic [1:0] RES_SNAP = 2'd3;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_BAD = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [1:0] RULE_DROP = 2'd0;
    localparam logic [1:0] RULE_COAL = 2'd1;
    localparam logic [1:0] RULE_REQ = 2'd2;

    localparam logic [1:0] REG_CAP = 2'd0;
    localparam logic [1:0] REG_SLIM = 2'd1;
    localparam logic [1:0] REG_KLIM = 2'd2;
    localparam logic [1:0] REG_PLIM = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_SHIFT, S_DRAIN, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic decide;    // classify enqueue
        logic scan_step; // test one entry, move pointer down
        logic shift_step;// close gap by one entry
        logic append;    // write item at tail
        logic drain_pop; // present head, shift down
        logic out_load;  // result register load
        logic [1:0] rtype;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic bad;
        logic room;
        logic req;
        logic scan_hit;
        logic scan_done;
        logic shift_done;
        logic drain_zero;
        logic drain_last;
    } t_stat;
endpackage
`default_nettype wire

@@ hdl/coalescing_event_queue.sv @@
`default_nettype none
// Coalescing event queue.
// Input channel i_valid/o_stall carries one command item; an item is
// taken when i_valid is high and o_stall low. Results leave on
// o_valid/i_stall, one result per edge with o_valid high and i_stall low;
// o_last marks the final result of an item. Configuration writes come on
// i_cfg_valid/o_cfg_ready (always ready) with register index and data.
// Snapshot and stored or refused enqueues pass through the decide and
// output states to the result. Full-queue enqueue: the scan walks entries
// newest first one per cycle, then on a match closes the gap one entry per cycle.
// A drain emits one event per cycle while the receiver does not stall.
// The block takes one item at a time; o_stall stays high until the last
// result of the item is loaded into the output register. A stalled
// receiver holds the output register and the controller waits.
// Reset clears level, sequence and counters and restores the default
// configuration; entry storage is not cleared.
module coalescing_event_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_source_id,
    input  wire logic [7:0]  i_source_length,
    input  wire logic [31:0] i_kind_id,
    input  wire logic [7:0]  i_kind_length,
    input  wire logic [63:0] i_payload_word,
    input  wire logic [7:0]  i_payload_length,
    input  wire logic [1:0]  i_loss_rule,
    input  wire logic [4:0]  i_drain_limit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_result_type,
    output logic [2:0]       o_status,
    output logic [31:0]      o_sequence_res,
    output logic [31:0]      o_out_source_id,
    output logic [31:0]      o_out_kind_id,
    output logic [63:0]      o_out_payload,
    output logic [1:0]       o_out_loss_rule,
    output logic             o_last,
    output logic [4:0]       o_queue_level,
    output logic [31:0]      o_coalesced_total,
    output logic [31:0]      o_dropped_total,
    output logic [31:0]      o_overflow_total
);
    import ceq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_free;

    assign o_cfg_ready = 1'b1;

    ceq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_out_free(w_out_free), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ceq_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_command, .i_source_id, .i_source_length, .i_kind_id, .i_kind_length,
        .i_payload_word, .i_payload_length, .i_loss_rule, .i_drain_limit,
        .i_cmd(w_cmd), .o_stat(w_stat), .i_out_stall(i_stall),
        .o_out_free(w_out_free), .o_valid, .o_result_type, .o_status,
        .o_sequence_res, .o_out_source_id, .o_out_kind_id, .o_out_payload,
        .o_out_loss_rule, .o_last, .o_queue_level, .o_coalesced_total,
        .o_dropped_total, .o_overflow_total
    );
endmodule
`default_nettype wire

@@ hdl/ceq_ctrl.sv @@
`default_nettype none
module ceq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_out_free,
    input  wire ceq_pkg::t_stat i_stat,
    output ceq_pkg::t_cmd      o_cmd
);
    import ceq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_stat.cmd)
                    CMD_ENQ: begin
                        o_cmd.decide = 1'b1;
                        if (i_stat.bad) n_state = S_OUT;
                        else if (i_stat.room || i_stat.req) n_state = S_OUT;
                        else n_state = S_SCAN;
                    end
                    CMD_DRAIN: n_state = S_DRAIN;
                    CMD_SNAP: n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_hit) n_state = S_SHIFT;
                else if (i_stat.scan_done) n_state = S_OUT;
                else o_cmd.scan_step = 1'b1;
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.append = 1'b1;
                    n_state = S_OUT;
                end else o_cmd.shift_step = 1'b1;
            end
            S_DRAIN: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.drain_zero) begin
                        o_cmd.rtype = RES_EMPTY;
                        o_cmd.last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rtype = RES_EVENT;
                        o_cmd.drain_pop = 1'b1;
                        o_cmd.last = i_stat.drain_last;
                        if (i_stat.drain_last) n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.cmd == CMD_SNAP) o_cmd.rtype = RES_SNAP;
                    else o_cmd.rtype = RES_RECEIPT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/ceq_dp.sv @@
`default_nettype none
module ceq_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic [1:0]    i_command,
    input  wire logic [31:0]   i_source_id,
    input  wire logic [7:0]    i_source_length,
    input  wire logic [31:0]   i_kind_id,
    input  wire logic [7:0]    i_kind_length,
    input  wire logic [63:0]   i_payload_word,
    input  wire logic [7:0]    i_payload_length,
    input  wire logic [1:0]    i_loss_rule,
    input  wire logic [4:0]    i_drain_limit,
    input  wire ceq_pkg::t_cmd i_cmd,
    output ceq_pkg::t_stat     o_stat,
    input  wire logic          i_out_stall,
    output logic               o_out_free,
    output logic               o_valid,
    output logic [1:0]         o_result_type,
    output logic [2:0]         o_status,
    output logic [31:0]        o_sequence_res,
    output logic [31:0]        o_out_source_id,
    output logic [31:0]        o_out_kind_id,
    output logic [63:0]        o_out_payload,
    output logic [1:0]         o_out_loss_rule,
    output logic               o_last,
    output logic [4:0]         o_queue_level,
    output logic [31:0]        o_coalesced_total,
    output logic [31:0]        o_dropped_total,
    output logic [31:0]        o_overflow_total
);
    import ceq_pkg::*;

    // entry storage: 16 entries, shifted one position per cycle
    logic [31:0] r_seq [QueueDepth];
    logic [31:0] r_src [QueueDepth];
    logic [31:0] r_kind [QueueDepth];
    logic [63:0] r_pay [QueueDepth];
    logic [1:0]  r_rule [QueueDepth];

    logic [4:0] r_cap;
    logic [7:0] r_slim, r_klim;
    logic [3:0] r_plim;
    logic [LvlW-1:0] r_fill;
    logic [31:0] r_nseq, r_ccnt, r_dcnt, r_ocnt;

    // captured item
    logic [1:0]  r_cmd;
    logic [31:0] r_isrc, r_ikind, r_iseq;
    logic [63:0] r_ipay;
    logic [1:0]  r_irule;
    logic [LvlW-1:0] r_dcount;
    logic        r_bad;
    logic [2:0]  r_st;
    logic [LvlW-1:0] r_ptr;   // scan position + 1, or shift position
    logic        r_hit;

    // config, with register clamps
    logic [LvlW-1:0] w_cap;
    logic [3:0] w_plim;
    logic w_bad;
    logic [63:0] w_mask;
    always_comb begin
        if (r_cap == 5'd0) w_cap = LvlW'(1);
        else if (32'(r_cap) > QueueDepth) w_cap = LvlW'(QueueDepth);
        else w_cap = LvlW'(r_cap);
        w_plim = (r_plim > 4'd8) ? 4'd8 : r_plim;
        w_bad = (i_source_length == 8'd0) || (i_source_length > r_slim) ||
                (i_kind_length == 8'd0) || (i_kind_length > r_klim) ||
                (i_payload_length > {4'd0, w_plim});
        for (int b = 0; b < 8; b++)
            w_mask[b*8 +: 8] = (i_payload_length > 8'(b)) ? 8'hFF : 8'h00;
    end

    logic [IdxW-1:0] w_pidx;
    assign w_pidx = IdxW'(r_ptr - LvlW'(1));
    logic w_match;
    assign w_match = (r_rule[w_pidx] == RULE_COAL) && (r_src[w_pidx] == r_isrc) &&
                     (r_kind[w_pidx] == r_ikind);

    always_comb begin
        o_stat.cmd = r_cmd;
        o_stat.bad = r_bad;
        o_stat.room = r_fill < w_cap;
        o_stat.req = (r_irule == RULE_REQ);
        o_stat.scan_hit = r_hit;
        o_stat.scan_done = (r_ptr == '0);
        o_stat.shift_done = (r_ptr + LvlW'(1) >= r_fill);
        o_stat.drain_zero = (r_dcount == '0);
        o_stat.drain_last = (r_dcount == LvlW'(1));
    end

    assign o_out_free = !o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 5'd16;
            r_slim <= 8'd255;
            r_klim <= 8'd255;
            r_plim <= 4'd8;
            r_fill <= '0;
            r_nseq <= '0;
            r_ccnt <= '0;
            r_dcnt <= '0;
            r_ocnt <= '0;
            r_cmd <= CMD_SNAP;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CAP: r_cap <= i_cfg_data[4:0];
                    REG_SLIM: r_slim <= i_cfg_data;
                    REG_KLIM: r_klim <= i_cfg_data;
                    REG_PLIM: r_plim <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) o_valid <= 1'b1;
            else if (o_valid && !i_out_stall) o_valid <= 1'b0;
            if (i_cmd.load) begin
                r_cmd <= i_command;
                r_bad <= w_bad;
                r_isrc <= i_source_id;
                r_ikind <= i_kind_id;
                r_irule <= i_loss_rule;
                r_ipay <= (i_payload_length < 8'd8) ? (i_payload_word & w_mask)
                                                    : i_payload_word;
                r_dcount <= (LvlW'(i_drain_limit) < r_fill) ? LvlW'(i_drain_limit) : r_fill;
                r_iseq <= '0;
                r_hit <= 1'b0;
                r_ptr <= r_fill;
            end
            if (i_cmd.decide && !r_bad) begin
                r_iseq <= r_nseq;
                r_nseq <= r_nseq + 32'd1;
                if (r_fill < w_cap) begin
                    r_st <= ST_STORED;
                    r_seq[r_fill[IdxW-1:0]] <= r_nseq;
                    r_src[r_fill[IdxW-1:0]] <= r_isrc;
                    r_kind[r_fill[IdxW-1:0]] <= r_ikind;
                    r_pay[r_fill[IdxW-1:0]] <= r_ipay;
                    r_rule[r_fill[IdxW-1:0]] <= r_irule;
                    r_fill <= r_fill + LvlW'(1);
                end else if (r_irule == RULE_REQ) begin
                    r_st <= ST_OVERFLOW;
                    r_ocnt <= r_ocnt + 32'd1;
                end else begin
                    r_st <= ST_DROPPED;
                end
            end else if (i_cmd.decide) begin
                r_st <= ST_BAD;
            end
            // scan from newest entry down
            if (i_cmd.scan_step) begin
                if (w_match) begin
                    r_hit <= 1'b1;
                    r_ptr <= r_ptr - LvlW'(1);
                    r_st <= ST_COALESCED;
                    r_ccnt <= r_ccnt + 32'd1;
                end else begin
                    r_ptr <= r_ptr - LvlW'(1);
                    if (r_ptr == LvlW'(1)) r_dcnt <= r_dcnt + 32'd1;
                end
            end
            if (i_cmd.shift_step) begin
                r_seq[r_ptr[IdxW-1:0]] <= r_seq[IdxW'(r_ptr + LvlW'(1))];
                r_src[r_ptr[IdxW-1:0]] <= r_src[IdxW'(r_ptr + LvlW'(1))];
                r_kind[r_ptr[IdxW-1:0]] <= r_kind[IdxW'(r_ptr + LvlW'(1))];
                r_pay[r_ptr[IdxW-1:0]] <= r_pay[IdxW'(r_ptr + LvlW'(1))];
                r_rule[r_ptr[IdxW-1:0]] <= r_rule[IdxW'(r_ptr + LvlW'(1))];
                r_ptr <= r_ptr + LvlW'(1);
            end
            // the new item lands where the last entry was
            if (i_cmd.append) begin
                r_seq[IdxW'(r_fill - LvlW'(1))] <= r_iseq;
                r_src[IdxW'(r_fill - LvlW'(1))] <= r_isrc;
                r_kind[IdxW'(r_fill - LvlW'(1))] <= r_ikind;
                r_pay[IdxW'(r_fill - LvlW'(1))] <= r_ipay;
                r_rule[IdxW'(r_fill - LvlW'(1))] <= r_irule;
            end
            if (i_cmd.out_load) begin
                o_result_type <= i_cmd.rtype;
                o_last <= i_cmd.last;
                o_status <= (i_cmd.rtype == RES_RECEIPT) ? r_st : ST_STORED;
                o_coalesced_total <= r_ccnt;
                o_dropped_total <= r_dcnt;
                o_overflow_total <= r_ocnt;
                if (i_cmd.drain_pop) begin
                    o_sequence_res <= r_seq[0];
                    o_out_source_id <= r_src[0];
                    o_out_kind_id <= r_kind[0];
                    o_out_payload <= r_pay[0];
                    o_out_loss_rule <= r_rule[0];
                    o_queue_level <= 5'(r_fill - r_dcount);
                end else begin
                    o_sequence_res <= (i_cmd.rtype == RES_RECEIPT) ? r_iseq : 32'd0;
                    o_out_source_id <= '0;
                    o_out_kind_id <= '0;
                    o_out_payload <= '0;
                    o_out_loss_rule <= '0;
                    o_queue_level <= 5'(r_fill);
                end
            end
            // pop: shift the whole queue down one place
            if (i_cmd.drain_pop) begin
                for (int k = 0; k < QueueDepth - 1; k++) begin
                    r_seq[k] <= r_seq[k+1];
                    r_src[k] <= r_src[k+1];
                    r_kind[k] <= r_kind[k+1];
                    r_pay[k] <= r_pay[k+1];
                    r_rule[k] <= r_rule[k+1];
                end
                r_fill <= r_fill - LvlW'(1);
                r_dcount <= r_dcount - LvlW'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ test/coalescing_event_queue_test.sv @@
`default_nettype none
module coalescing_event_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ceq_pkg::*;

    localparam int IdleLimit = 4000;
    localparam int Settle = 60;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] source_id;
        logic [7:0]  source_length;
        logic [31:0] kind_id;
        logic [7:0]  kind_length;
        logic [63:0] payload_word;
        logic [7:0]  payload_length;
        logic [1:0]  loss_rule;
        logic [4:0]  drain_limit;
    } t_event_cmd;

    localparam int CmdW = $bits(t_event_cmd);

    typedef struct packed {
        logic [1:0]  result_type;
        logic [2:0]  status;
        logic [31:0] sequence_res;
        logic [31:0] source_id;
        logic [31:0] kind_id;
        logic [63:0] payload;
        logic [1:0]  loss_rule;
        logic        last;
        logic [4:0]  queue_level;
        logic [31:0] coalesced_total;
        logic [31:0] dropped_total;
        logic [31:0] overflow_total;
    } t_result;

    typedef struct packed {
        logic [31:0] sequence_num;
        logic [31:0] source_id;
        logic [31:0] kind_id;
        logic [63:0] payload;
        logic [1:0]  loss_rule;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_event_cmd drv = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_result got;

    coalescing_event_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(drv.command), .i_source_id(drv.source_id),
        .i_source_length(drv.source_length), .i_kind_id(drv.kind_id),
        .i_kind_length(drv.kind_length), .i_payload_word(drv.payload_word),
        .i_payload_length(drv.payload_length), .i_loss_rule(drv.loss_rule),
        .i_drain_limit(drv.drain_limit),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_type(got.result_type), .o_status(got.status),
        .o_sequence_res(got.sequence_res), .o_out_source_id(got.source_id),
        .o_out_kind_id(got.kind_id), .o_out_payload(got.payload),
        .o_out_loss_rule(got.loss_rule), .o_last(got.last),
        .o_queue_level(got.queue_level), .o_coalesced_total(got.coalesced_total),
        .o_dropped_total(got.dropped_total), .o_overflow_total(got.overflow_total)
    );

    always #1 i_clk = ~i_clk;

    // queue model state and configuration
    t_entry      model_q[$];
    logic [31:0] next_seq, coal_cnt, drop_cnt, ovf_cnt;
    logic [4:0]  cfg_cap;
    logic [7:0]  cfg_slim, cfg_klim;
    logic [3:0]  cfg_plim;

    t_event_cmd  pending_cmds[$];
    t_result     expected_results[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet = 0;     // no idling in the final part
    bit          hold_off = 0;  // long receiver stall request
    int          stall_burst = 0, gap_burst = 0;
    bit          taken = 0;

    function automatic t_result mk(logic [1:0] rt, logic [2:0] st, logic [31:0] sq,
                                   logic last);
        t_result r;
        r = '0;
        r.result_type = rt;
        r.status = st;
        r.sequence_res = sq;
        r.last = last;
        return r;
    endfunction

    function automatic void add_cmd(input t_event_cmd c);
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic t_event_cmd take_cmd();
        t_event_cmd c;
        c = pending_cmds[0];
        pending_cmds.delete(0);
        return c;
    endfunction

    task automatic predict_queue(input t_event_cmd c);
        t_result rs[$];
        t_entry e;
        int cap, plim, cnt;
        bit found;
        rs = {};
        cap = (cfg_cap == 0) ? 1 : ((cfg_cap > QueueDepth) ? QueueDepth : cfg_cap);
        plim = (cfg_plim > 8) ? 8 : cfg_plim;
        if (c.command == CMD_ENQ) begin
            if (c.source_length == 0 || c.source_length > cfg_slim ||
                c.kind_length == 0 || c.kind_length > cfg_klim ||
                c.payload_length > plim) begin
                rs = {rs, mk(RES_RECEIPT, ST_BAD, 32'd0, 1'b1)};
            end else begin
                e.sequence_num = next_seq;
                e.source_id = c.source_id;
                e.kind_id = c.kind_id;
                e.payload = c.payload_word;
                if (c.payload_length < 8)
                    e.payload = c.payload_word & ((64'd1 << (c.payload_length * 8)) - 1);
                e.loss_rule = c.loss_rule;
                next_seq = next_seq + 1;
                if (model_q.size() < cap) begin
                    model_q = {model_q, e};
                    rs = {rs, mk(RES_RECEIPT, ST_STORED, e.sequence_num, 1'b1)};
                end else if (c.loss_rule == RULE_REQ) begin
                    ovf_cnt = ovf_cnt + 1;
                    rs = {rs, mk(RES_RECEIPT, ST_OVERFLOW, e.sequence_num, 1'b1)};
                end else begin
                    found = 0;
                    for (int i = model_q.size() - 1; i >= 0 && !found; i--) begin
                        if (model_q[i].loss_rule == RULE_COAL &&
                            model_q[i].source_id == c.source_id &&
                            model_q[i].kind_id == c.kind_id) begin
                            model_q.delete(i);
                            found = 1;
                        end
                    end
                    if (found) begin
                        model_q = {model_q, e};
                        coal_cnt = coal_cnt + 1;
                        rs = {rs, mk(RES_RECEIPT, ST_COALESCED, e.sequence_num, 1'b1)};
                    end else begin
                        drop_cnt = drop_cnt + 1;
                        rs = {rs, mk(RES_RECEIPT, ST_DROPPED, e.sequence_num, 1'b1)};
                    end
                end
            end
        end else if (c.command == CMD_DRAIN) begin
            cnt = (c.drain_limit < model_q.size()) ? c.drain_limit : model_q.size();
            if (cnt == 0)
                rs = {rs, mk(RES_EMPTY, ST_STORED, 32'd0, 1'b1)};
            for (int k = 0; k < cnt; k++) begin
                e = model_q[0];
                model_q.delete(0);
                rs = {rs, mk(RES_EVENT, ST_STORED, e.sequence_num, k == cnt - 1)};
                rs[k].source_id = e.source_id;
                rs[k].kind_id = e.kind_id;
                rs[k].payload = e.payload;
                rs[k].loss_rule = e.loss_rule;
            end
        end else if (c.command == CMD_SNAP) begin
            rs = {rs, mk(RES_SNAP, ST_STORED, 32'd0, 1'b1)};
        end
        // level and counters as after the whole step
        foreach (rs[k]) begin
            rs[k].queue_level = 5'(model_q.size());
            rs[k].coalesced_total = coal_cnt;
            rs[k].dropped_total = drop_cnt;
            rs[k].overflow_total = ovf_cnt;
            expected_results = {expected_results, rs[k]};
        end
    endtask

    // input acceptance feeds the predictor
    always @(posedge i_clk) begin
        taken = i_rst_n && i_valid && !o_stall;
        if (taken) begin
            predict_queue(take_cmd());
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !taken) begin
            // hold the stalled item
        end else if (gap_burst > 0) begin
            gap_burst <= gap_burst - 1;
            i_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_burst <= $urandom_range(1, 8) - 1;
            i_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            // offer the next waiting item
            drv <= pending_cmds[0];
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_off)
            i_stall <= 1'b1;
        else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_burst <= $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else
            i_stall <= 1'b0;
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_off ||
            (pending_cmds.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("coalescing_event_queue regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_CAP:  cfg_cap = val[4:0];
            REG_SLIM: cfg_slim = val;
            REG_KLIM: cfg_klim = val;
            default:  cfg_plim = val[3:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    function automatic t_event_cmd enq_cmd(logic [31:0] src, logic [31:0] kind,
                                           logic [1:0] rule);
        t_event_cmd c;
        c.command = CMD_ENQ;
        c.source_id = src;
        c.kind_id = kind;
        c.source_length = 8'($urandom_range(1, 40));
        c.kind_length = 8'($urandom_range(1, 40));
        c.payload_word = {$urandom, $urandom};
        c.payload_length = 8'($urandom_range(0, 8));
        c.loss_rule = rule;
        c.drain_limit = 5'($urandom);
        return c;
    endfunction

    function automatic t_event_cmd drain_cmd(logic [4:0] lim);
        t_event_cmd c;
        c = CmdW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.command = CMD_DRAIN;
        c.drain_limit = lim;
        return c;
    endfunction

    // one random item, biased toward colliding tags
    function automatic t_event_cmd rand_cmd();
        t_event_cmd c;
        int r;
        r = $urandom_range(0, 99);
        c = enq_cmd($urandom_range(0, 3), $urandom_range(0, 2), 2'($urandom_range(0, 3)));
        if (r < 5) begin
            c.source_id = $urandom;
            c.kind_id = $urandom;
        end else if (r < 10) begin
            c.source_length = 8'($urandom);
            c.kind_length = 8'($urandom);
            c.payload_length = 8'($urandom);
        end else if (r < 22) begin
            c = drain_cmd(5'($urandom_range(0, 16)));
            if (r < 13) c.drain_limit = 5'($urandom);
        end else if (r < 26) begin
            c.command = CMD_SNAP;
        end else if (r < 28) begin
            c.command = 2'd3;
        end
        return c;
    endfunction

    initial begin
        t_event_cmd c;
        model_q = {};
        next_seq = 0; coal_cnt = 0; drop_cnt = 0; ovf_cnt = 0;
        cfg_cap = 16; cfg_slim = 255; cfg_klim = 255; cfg_plim = 8;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, bad fields, every command
        c = enq_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, RULE_COAL);
        c.source_length = 8'hFF; c.kind_length = 8'hFF;
        c.payload_word = '1; c.payload_length = 8;
        add_cmd(c);
        c = enq_cmd(0, 0, 2'd3); c.payload_word = '1; c.payload_length = 3;
        add_cmd(c);
        c = enq_cmd(1, 1, RULE_DROP); c.source_length = 0; add_cmd(c);
        c = enq_cmd(1, 1, RULE_DROP); c.kind_length = 0; add_cmd(c);
        c = enq_cmd(1, 1, RULE_DROP); c.payload_length = 8'hFF; add_cmd(c);
        c = enq_cmd(2, 2, RULE_REQ); c.payload_length = 0; add_cmd(c);
        c.command = CMD_SNAP; add_cmd(c);
        c.command = 2'd3; add_cmd(c);
        add_cmd(drain_cmd(5'd31));
        add_cmd(drain_cmd(5'd0));
        add_cmd(drain_cmd(5'd1));
        wait_idle();

        // small queue: overflow, coalescing, drop, limits
        write_reg(REG_CAP, 8'd2);
        write_reg(REG_SLIM, 8'd4);
        write_reg(REG_KLIM, 8'd0);
        write_reg(REG_PLIM, 8'd15);
        add_cmd(enq_cmd(1, 1, RULE_COAL));
        wait_idle();
        write_reg(REG_KLIM, 8'd255);
        c = enq_cmd(3, 3, RULE_COAL); c.source_length = 4; add_cmd(c);
        c = enq_cmd(3, 3, RULE_DROP); c.source_length = 5; add_cmd(c);
        c = enq_cmd(5, 5, RULE_COAL); c.source_length = 1; add_cmd(c);
        c = enq_cmd(3, 3, RULE_REQ); c.source_length = 1; add_cmd(c);
        c = enq_cmd(3, 3, RULE_DROP); c.source_length = 1; add_cmd(c);
        c = enq_cmd(9, 9, RULE_COAL); c.source_length = 1; add_cmd(c);
        wait_idle();
        // capacity below level counts as full
        write_reg(REG_CAP, 8'd0);
        c = enq_cmd(9, 9, 2'd3); c.source_length = 1; add_cmd(c);
        add_cmd(drain_cmd(5'd16));
        wait_idle();

        // random phases across several settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_CAP, ph == 0 ? 8'd16 :
                      (ph == 3 ? 8'd31 : 8'($urandom_range(1, 8))));
            write_reg(REG_SLIM, ph == 0 ? 8'd255 : 8'($urandom_range(20, 255)));
            write_reg(REG_KLIM, ph == 1 ? 8'd1 : 8'd255);
            write_reg(REG_PLIM, ph == 2 ? 8'd0 : 8'd8);
            if (ph == 3) quiet = 1;
            for (int n = 0; n < 45; n++) add_cmd(rand_cmd());
            if (ph == 1) begin
                // long receiver hold-off while items keep coming
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("coalescing_event_queue regression: pass");
        else
            $display("coalescing_event_queue regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
